/* design/lisl_pkg.sv */
// ---------------------------------------------------------------------------
// lisl_pkg: shared types and constants for the LIS length unit
// Request and response field widths and the queued request type.
// ---------------------------------------------------------------------------
package lisl_pkg;

   localparam int VALUE_W  = 32;
   localparam int LENGTH_W = 11;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [LENGTH_W-1:0]       length_type;

   typedef struct packed {
      value_type value;
      logic      last;
   } lisl_item_type;

endpackage

/* design/lisl_if.sv */
// ---------------------------------------------------------------------------
// lisl_if: valid/ready channels of the LIS length unit
// Request channel carries one sequence element; response channel the length.
// ---------------------------------------------------------------------------
interface lisl_req_if;
   import lisl_pkg::*;

   logic      valid;
   logic      ready;
   value_type value;
   logic      last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface lisl_rsp_if;
   import lisl_pkg::*;

   logic       valid;
   logic       ready;
   length_type length;
   logic       overflow;

   modport source (output valid, output length, output overflow, input ready);
   modport sink   (input valid, input length, input overflow, output ready);
endinterface

/* design/lisl_front.sv */
// ---------------------------------------------------------------------------
// lisl_front: request intake
// Two-entry queue that takes requests and hands them to the search engine.
// ---------------------------------------------------------------------------
module lisl_front (
   input  logic                   clock,
   input  logic                   reset,
   lisl_req_if.sink               req_ch,
   output lisl_pkg::lisl_item_type item,
   output logic                   item_valid,
   input  logic                   item_pop
);
   import lisl_pkg::*;

   lisl_item_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    fill_ff, fill_in;
   logic          push;
   logic          pop;

   assign req_ch.ready = (fill_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign item_valid   = (fill_ff != 2'd0);
   assign pop          = item_pop && item_valid;
   assign item         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{value: req_ch.value, last: req_ch.last};
      end
   end

endmodule

/* design/lisl_back.sv */
// ---------------------------------------------------------------------------
// lisl_back: pile-top search engine
// Binary search over the pile-top memory, one read per step, then a
// replace, append or overflow flag; emits the length on a sequence's last element.
// ---------------------------------------------------------------------------
module lisl_back #(
   parameter int MAX_PILES = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lisl_pkg::lisl_item_type item,
   input  logic                    item_valid,
   output logic                    item_pop,
   lisl_rsp_if.source              rsp_ch
);
   import lisl_pkg::*;

   localparam int AW = $clog2(MAX_PILES);
   localparam int CW = $clog2(MAX_PILES + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PILES);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   value_type  mem [MAX_PILES];
   value_type  rdata_ff;

   logic [1:0]    state_ff, state_in;
   value_type     value_ff, value_in;
   logic          last_ff, last_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          rsp_valid_ff, rsp_valid_in;
   length_type    rsp_len_ff, rsp_len_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.length   = rsp_len_ff;
   assign rsp_ch.overflow = rsp_ovf_ff;

   always_comb begin
      logic [CW-1:0]          lo_n;
      logic [CW-1:0]          hi_n;
      logic [CW-1:0]          mid_n;
      logic [CW-1:0]          cnt_n;
      logic                   ovf_n;
      logic [CW+LENGTH_W-1:0] len_wide;

      state_in     = state_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_len_in   = rsp_len_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      item_pop     = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      lo_n         = lo_ff;
      hi_n         = hi_ff;
      mid_n        = mid_ff;
      cnt_n        = count_ff;
      ovf_n        = ovf_ff;
      len_wide     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               value_in = item.value;
               last_in  = item.last;
               lo_in    = '0;
               hi_in    = count_ff;
               if (count_ff != '0) begin
                  mid_in   = count_ff >> 1;
                  rd_en    = 1'b1;
                  rd_addr  = mid_in[AW-1:0];
                  state_in = S_CMP;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_CMP: begin
            // rdata_ff holds the top at mid_ff
            if (rdata_ff >= value_ff) begin
               hi_n = mid_ff;
            end else begin
               lo_n = mid_ff + CW'(1);
            end
            lo_in = lo_n;
            hi_in = hi_n;
            if (lo_n < hi_n) begin
               mid_n   = lo_n + ((hi_n - lo_n) >> 1);
               mid_in  = mid_n;
               rd_en   = 1'b1;
               rd_addr = mid_n[AW-1:0];
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // lo_ff is the insertion point; a last request waits for a free slot
            if (!last_ff || !rsp_valid_ff || rsp_ch.ready) begin
               if (lo_ff < count_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = lo_ff[AW-1:0];
               end else if (count_ff < MAX_CNT) begin
                  wr_en   = 1'b1;
                  wr_addr = count_ff[AW-1:0];
                  cnt_n   = count_ff + CW'(1);
               end else begin
                  ovf_n = 1'b1;
               end
               if (last_ff) begin
                  len_wide     = {{LENGTH_W{1'b0}}, cnt_n};
                  rsp_valid_in = 1'b1;
                  rsp_len_in   = len_wide[LENGTH_W-1:0];
                  rsp_ovf_in   = ovf_n;
                  count_in     = '0;
                  ovf_in       = 1'b0;
               end else begin
                  count_in = cnt_n;
                  ovf_in   = ovf_n;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      last_ff    <= last_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      rsp_len_ff <= rsp_len_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("pile count above table depth");

   a_search_open: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> lo_ff < hi_ff)
      else $error("compare step with empty search range");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> count_ff == MAX_CNT)
      else $error("overflow flagged with table not full");

   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && last_ff && rsp_valid_ff && !rsp_ch.ready)
      |=> (state_ff == S_FIN && $stable(count_ff)))
      else $error("last request retired while response slot busy");

endmodule

/* design/longest_increasing_subsequence_length_unit.sv */
// ---------------------------------------------------------------------------
// longest_increasing_subsequence_length_unit: LIS length by patience sort
// Keeps sorted pile tops in a memory; reports the pile count at sequence end.
//
//   channel   dir   payload                       handshake
//   req_ch    in    value[31:0] signed, last      valid/ready
//   rsp_ch    out   length[10:0], overflow        valid/ready
//
// In the search engine a request first issues the first read (skipped when there
// are no piles), then does one compare per binary-search step (single memory read
// port), then replaces or appends a top, or flags overflow when the table is full.
// A two-entry queue takes requests while the engine searches.
// Synchronous reset clears counts and control; the memory needs no clearing.
// A last request waits in the engine while the response register is held.
// ---------------------------------------------------------------------------
module longest_increasing_subsequence_length_unit #(
   parameter int MAX_PILES = 1024
) (
   input  logic       clock,
   input  logic       reset,
   lisl_req_if.sink   req_ch,
   lisl_rsp_if.source rsp_ch
);
   import lisl_pkg::*;

   lisl_item_type item;
   logic          item_valid;
   logic          item_pop;

   lisl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop)
   );

   lisl_back #(
      .MAX_PILES (MAX_PILES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
